[rtl/core/bba_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: transaction
// payloads, request and status codes, controller states, control structs.
// ---------------------------------------------------------------------------
package bba_pkg;

  // fixed field widths
  localparam int ID_W        = 10;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int WORD_W      = 32;
  localparam int WORD_IDX_W  = 5;

  // request codes
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FORMAT = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  // result codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOTUSED = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL    = 2'd0,
    CFG_RESERVED = 2'd1,
    CFG_FIRST    = 2'd2
  } cfg_idx_t;

  // input transaction
  typedef struct packed {
    opcode_t           opcode;
    logic [ID_W-1:0]   block_id;
  } req_t;

  // output transaction
  typedef struct packed {
    logic [ID_W-1:0]   granted_id;
    status_t           status;
  } rsp_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_SCAN,
    S_ALLOC_WR,
    S_FREE_RD,
    S_FREE_CHK,
    S_FORMAT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    row_clear;
    logic    read_row;
    logic    sweep_write;
    logic    fill_zero;
    logic    hit_capture;
    logic    alloc_write;
    logic    free_read;
    logic    free_write;
    logic    res_load;
    status_t res_status;
    logic    res_grant;
    logic    out_load;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t in_op;
    logic    sweep_last;
    logic    scan_hit;
    logic    scan_end;
    logic    id_in_range;
    logic    bit_set;
    logic    out_free;
  } bba_stat_t;

endpackage : bba_pkg
`default_nettype wire

[rtl/core/bba_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : bba_ram
`default_nettype wire

[rtl/core/bba_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_datapath
// Configuration registers, bitmap word memory, row counters, first-free
// priority encoder, fill pattern generator and the output register.
// ---------------------------------------------------------------------------
module bba_datapath #(
  parameter int NUM_BLOCKS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0]      cfg_data,
  input  wire bba_pkg::req_t                  in_data,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output bba_pkg::rsp_t                       out_data,
  input  wire bba_pkg::bba_cmd_t              cmd,
  output bba_pkg::bba_stat_t                  stat
);

  import bba_pkg::*;

  localparam int WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // bits of a word whose ids lie below lim
  function automatic logic [WORD_W-1:0] low_mask(input logic [LW-1:0] lim,
                                                 input logic [LW-1:0] base);
    logic [LW-1:0] remain;
    remain = lim - base;
    if (lim <= base) begin
      return '0;
    end else if (remain >= LW'(WORD_W)) begin
      return '1;
    end else begin
      return (WORD_W'(1) << remain[WORD_IDX_W-1:0]) - WORD_W'(1);
    end
  endfunction

  // configuration registers
  logic [CFG_W-1:0] total_blocks;
  logic [CFG_W-1:0] reserved_blocks;
  logic [CFG_W-1:0] first_data_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks     <= CFG_W'(1024);
      reserved_blocks  <= CFG_W'(1);
      first_data_block <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL:    total_blocks     <= cfg_data;
        CFG_RESERVED: reserved_blocks  <= cfg_data;
        CFG_FIRST:    first_data_block <= cfg_data;
        default:      ;
      endcase
    end
  end

  // request capture
  logic [ID_W-1:0] req_id;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_id <= in_data.block_id;
    end
  end

  // limits
  logic [LW-1:0] num_ext;
  logic [LW-1:0] scan_lim;
  logic [LW-1:0] fill_lim;
  logic [LW-1:0] id_ext;
  logic [ROW_W-1:0] id_row;
  logic [WORD_W-1:0] id_bit;

  assign num_ext  = LW'(NUM_BLOCKS);
  assign scan_lim = (LW'(total_blocks) < num_ext) ? LW'(total_blocks) : num_ext;
  assign fill_lim = cmd.fill_zero ? '0 :
                    ((LW'(reserved_blocks) < num_ext) ? LW'(reserved_blocks) : num_ext);
  assign id_ext   = LW'(req_id);
  assign id_row   = id_ext[WORD_IDX_W +: ROW_W];
  assign id_bit   = WORD_W'(1) << req_id[WORD_IDX_W-1:0];

  // row counters
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] chk_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      chk_row <= '0;
    end else if (cmd.row_clear) begin
      row <= '0;
    end else if (cmd.read_row) begin
      chk_row <= row;
      row     <= row + ROW_W'(1);
    end else if (cmd.sweep_write) begin
      row <= row + ROW_W'(1);
    end
  end

  // bitmap memory
  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ROW_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = cmd.free_read ? id_row : row;

  // first free bit of the row just read
  logic [LW-1:0]         chk_base;
  logic [WORD_W-1:0]     free_vec;
  logic [WORD_IDX_W-1:0] free_idx;

  assign chk_base = LW'({chk_row, {WORD_IDX_W{1'b0}}});
  assign free_vec = ~ram_rdata & low_mask(scan_lim, chk_base);

  always_comb begin
    free_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        free_idx = WORD_IDX_W'(j);
      end
    end
  end

  // hit capture
  logic [ROW_W-1:0]  hit_row;
  logic [WORD_W-1:0] hit_word;
  logic [LW-1:0]     hit_id;

  always_ff @(posedge clk) begin
    if (cmd.hit_capture) begin
      hit_row  <= chk_row;
      hit_word <= ram_rdata | (WORD_W'(1) << free_idx);
      hit_id   <= chk_base + LW'(free_idx);
    end
  end

  // memory write select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row;
    ram_wdata = low_mask(fill_lim, LW'({row, {WORD_IDX_W{1'b0}}}));
    priority if (cmd.sweep_write) begin
      ram_we = 1'b1;
    end else if (cmd.alloc_write) begin
      ram_we    = 1'b1;
      ram_waddr = hit_row;
      ram_wdata = hit_word;
    end else if (cmd.free_write) begin
      ram_we    = 1'b1;
      ram_waddr = id_row;
      ram_wdata = ram_rdata & ~id_bit;
    end
  end

  // pending result
  status_t         res_status;
  logic [ID_W-1:0] res_id;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_id     <= cmd.res_grant ? hit_id[ID_W-1:0] : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.granted_id <= res_id;
      out_data.status     <= res_status;
    end
  end

  // status to controller
  always_comb begin
    stat.in_op       = in_data.opcode;
    stat.sweep_last  = (row == ROW_W'(WORDS - 1));
    stat.scan_hit    = |free_vec;
    stat.scan_end    = (scan_lim <= chk_base + LW'(WORD_W));
    stat.id_in_range = (id_ext >= LW'(first_data_block)) &&
                       (id_ext < LW'(total_blocks)) && (id_ext < num_ext);
    stat.bit_set     = |(ram_rdata & id_bit);
    stat.out_free    = !out_valid || !out_stall;
  end

endmodule : bba_datapath
`default_nettype wire

[rtl/core/bba_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_ctrl
// Controller state machine: clearing pass, allocate scan, free check,
// format sweep and result hand-off.
// ---------------------------------------------------------------------------
module bba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t       cmd
);

  import bba_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (stat.in_op)
            OP_ALLOC:  state_next = S_ALLOC_RD;
            OP_FREE:   state_next = S_FREE_RD;
            OP_FORMAT: state_next = S_FORMAT;
            OP_NOP:    state_next = S_DONE;
          endcase
        end
      end
      S_ALLOC_RD: state_next = S_ALLOC_SCAN;
      S_ALLOC_SCAN: begin
        if (stat.scan_hit) begin
          state_next = S_ALLOC_WR;
        end else if (stat.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_ALLOC_WR: state_next = S_DONE;
      S_FREE_RD: begin
        state_next = stat.id_in_range ? S_FREE_CHK : S_DONE;
      end
      S_FREE_CHK: state_next = S_DONE;
      S_FORMAT: begin
        if (stat.sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.sweep_write = 1'b1;
        cmd.fill_zero   = 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          cmd.row_clear = 1'b1;
          if (stat.in_op == OP_NOP) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
          end
        end
      end
      S_ALLOC_RD: begin
        cmd.read_row = 1'b1;
      end
      S_ALLOC_SCAN: begin
        if (stat.scan_hit) begin
          cmd.hit_capture = 1'b1;
        end else if (stat.scan_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FULL;
        end else begin
          cmd.read_row = 1'b1;
        end
      end
      S_ALLOC_WR: begin
        cmd.alloc_write = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_status  = ST_OK;
        cmd.res_grant   = 1'b1;
      end
      S_FREE_RD: begin
        if (stat.id_in_range) begin
          cmd.free_read = 1'b1;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_RANGE;
        end
      end
      S_FREE_CHK: begin
        cmd.res_load = 1'b1;
        if (stat.bit_set) begin
          cmd.free_write = 1'b1;
          cmd.res_status = ST_OK;
        end else begin
          cmd.res_status = ST_NOTUSED;
        end
      end
      S_FORMAT: begin
        cmd.sweep_write = 1'b1;
        if (stat.sweep_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
        end
      end
      S_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule : bba_ctrl
`default_nettype wire

[rtl/core/bitmap_block_allocator_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit disk block allocator over a used-block bitmap held as 32-bit
// words in a RAM; serves allocate, free and format requests.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid / in_stall  in_data   (opcode, block_id)
//  out       out_valid/ out_stall out_data  (granted_id, status)
//  cfg       cfg_we               cfg_index, cfg_data
//
//  allocate: reads the bitmap words in order, one RAM read each, up to
//    ceil(NUM_BLOCKS/32) words; free: one word read (none if out of range)
//  format: sweeps every word; unused opcode: result without map access
//  after reset a clearing pass writes every word
//  a new transaction is taken while a result waits in the output register;
//    out_stall holds the block in its final state when a second result is ready
// ---------------------------------------------------------------------------
module bitmap_block_allocator_top #(
  parameter int NUM_BLOCKS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire bba_pkg::req_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output bba_pkg::rsp_t                       out_data
);

  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // controller
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule : bitmap_block_allocator_top
`default_nettype wire

[rtl/core/bba_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bba_checker
// Port-level checks of the allocator: transaction accounting, result
// encoding and output hold under stall.
// ---------------------------------------------------------------------------
module bba_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire bba_pkg::rsp_t out_data
);

  import bba_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] outstanding;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + 2'd1;
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  // a result only for a request taken earlier
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outstanding != 2'd0))
    else $error("result without pending request");

  // at most one in work plus one waiting
  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("too many requests in flight");

  // the block is busy in the cycle after it takes a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("request taken while busy");

  // an error status never grants a block
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.granted_id == '0))
    else $error("granted id with error status");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule : bba_checker

bind bitmap_block_allocator_top bba_checker u_bba_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
